// File: design/lofm_pkg.sv
// Shared constants, state and operation codes, and helper functions for the line orientation core.
package lofm_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int COORD_W    = 16;
    localparam int CNT_W      = 13;
    localparam int SUM_W      = 28;
    localparam int SQ_W       = 43;
    localparam int XY_W       = 44;
    localparam int MUL_W      = 29;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int LO_W       = 22;
    localparam int ACC_W      = 60;
    localparam int MAG_W      = 61;
    localparam int CRD_W      = 34;
    localparam int ANG_W      = 33;
    localparam int ITERS      = 30;
    localparam int ITER_W     = 5;
    localparam int AZ_W       = 16;
    localparam int W_W        = 34;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_XX,
        S_MUL_YY,
        S_MUL_XY,
        S_MOM,
        S_DRAIN,
        S_ABS,
        S_NORM,
        S_CORDIC,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        MAC_NONE,
        MAC_SXX,
        MAC_SYY,
        MAC_SXY,
        MAC_X_LOAD,
        MAC_X_ADD,
        MAC_X_SUB,
        MAC_Y_LOAD,
        MAC_Y_ADD,
        MAC_Y_SUB
    } t_mac_op;

    typedef enum logic [2:0] {
        MOM_XX_LO,
        MOM_XX_HI,
        MOM_SX_SQ,
        MOM_SY_SQ,
        MOM_XY_LO,
        MOM_XY_HI,
        MOM_SX_SY
    } t_mom_step;

    function automatic logic [31:0] cordic_angle(input logic [ITER_W-1:0] i);
        case (i)
            5'd0:    return 32'h20000000;
            5'd1:    return 32'h12E4051E;
            5'd2:    return 32'h09FB385B;
            5'd3:    return 32'h051111D4;
            5'd4:    return 32'h028B0D43;
            5'd5:    return 32'h0145D7E1;
            5'd6:    return 32'h00A2F61E;
            5'd7:    return 32'h00517C55;
            5'd8:    return 32'h0028BE53;
            5'd9:    return 32'h00145F2F;
            5'd10:   return 32'h000A2F98;
            5'd11:   return 32'h000517CC;
            5'd12:   return 32'h00028BE6;
            5'd13:   return 32'h000145F3;
            5'd14:   return 32'h0000A2FA;
            5'd15:   return 32'h0000517D;
            5'd16:   return 32'h000028BE;
            5'd17:   return 32'h0000145F;
            5'd18:   return 32'h00000A30;
            5'd19:   return 32'h00000518;
            5'd20:   return 32'h0000028C;
            5'd21:   return 32'h00000146;
            5'd22:   return 32'h000000A3;
            5'd23:   return 32'h00000051;
            5'd24:   return 32'h00000029;
            5'd25:   return 32'h00000014;
            5'd26:   return 32'h0000000A;
            5'd27:   return 32'h00000005;
            5'd28:   return 32'h00000003;
            5'd29:   return 32'h00000001;
            default: return 32'h00000000;
        endcase
    endfunction

    // Arithmetic right shift that truncates toward zero.
    function automatic logic signed [CRD_W-1:0] shr_tz(
        input logic signed [CRD_W-1:0] v,
        input logic [ITER_W-1:0]       s
    );
        logic [CRD_W-1:0] mag;
        mag = v[CRD_W-1] ? unsigned'(-v) : unsigned'(v);
        mag = mag >> s;
        return v[CRD_W-1] ? -signed'(mag) : signed'(mag);
    endfunction

endpackage

// File: design/line_orientation_from_moments_core.sv
// Line orientation core: moment accumulation, moment products, normalization and CORDIC atan2.
// Accepting a kept point starts three multiplier passes; a dropped middle point needs none.
// A last point adds 7 moment multiplies, a drain step, a sign capture step, normalization and
// 30 CORDIC iterations (both skipped when the moments are zero), then loads the result register.
// The result register frees the input side while a result waits, except when a second result is due.
// Synchronous active-low reset clears sums, count, drop flag, out_valid, state, step and MAC op.
module line_orientation_from_moments_core import lofm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic                    i_last_point,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [AZ_W-1:0]         o_azimuth,
    output logic [CNT_W-1:0]        o_point_count,
    output logic                    o_overflow
);

    localparam logic [MAG_W-1:0] M_RIGHT4 = MAG_W'(1) << 33;
    localparam logic [MAG_W-1:0] M_RIGHT1 = MAG_W'(1) << 30;
    localparam logic [MAG_W-1:0] M_LEFT4  = MAG_W'(1) << 25;
    localparam logic [MAG_W-1:0] M_LEFT1  = MAG_W'(1) << 29;
    localparam logic signed [CRD_W-1:0] C_LO = CRD_W'(1) << 29;
    localparam logic signed [CRD_W-1:0] C_HI = CRD_W'(1) << 30;
    localparam logic signed [ANG_W-1:0] Z_MAX = ANG_W'(1) << 30;
    localparam logic [W_W-1:0] W_HALF  = W_W'(1) << 31;
    localparam logic [W_W-1:0] W_FULL  = W_W'(1) << 32;
    localparam logic [W_W-1:0] W_ROUND = W_W'(1) << 15;
    localparam logic [AZ_W-1:0] AZ_NO_MOMENT = AZ_W'(32768);

    t_state    r_state, n_state;
    t_mac_op   r_mac_op, mac_op;
    t_mom_step r_step;

    logic signed [COORD_W-1:0] r_x, r_y;
    logic                      r_last;
    logic [CNT_W-1:0]          r_count;
    logic signed [SUM_W-1:0]   r_sum_x, r_sum_y;
    logic signed [SQ_W-1:0]    r_sum_xx, r_sum_yy;
    logic signed [XY_W-1:0]    r_sum_xy;
    logic                      r_dropped;
    logic signed [ACC_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]   r_acc_x, r_acc_y;
    logic [MAG_W-1:0]          r_ax, r_ay;
    logic                      r_neg_x, r_neg_y, r_zero;
    logic signed [CRD_W-1:0]   r_cx, r_cy;
    logic signed [ANG_W-1:0]   r_z;
    logic [ITER_W-1:0]         r_iter;
    logic                      r_out_valid;
    logic [AZ_W-1:0]           r_azimuth;
    logic [CNT_W-1:0]          r_point_count;
    logic                      r_overflow;

    logic                      in_fire, has_room, out_free, acc_zero;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic                      mac_shift;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   prod_sh;
    logic signed [XY_W-1:0]    dxx;
    logic signed [MAG_W-1:0]   x_ext, y_ext2;
    logic [MAG_W-1:0]          ax_abs, ay_abs, mag_max;
    logic [MAG_W-1:0]          n_ax, n_ay;
    logic                      norm_done;
    logic signed [CRD_W-1:0]   sx, sy, n_cx, n_cy;
    logic signed [ANG_W-1:0]   ang, n_z, z_clamp;
    logic [W_W-1:0]            w, w_round;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign has_room   = (r_count < CNT_W'(MAX_POINTS));
    assign out_free   = !r_out_valid || i_out_ready;
    assign acc_zero   = (r_acc_x == '0) && (r_acc_y == '0);
    assign dxx        = XY_W'(r_sum_xx) - XY_W'(r_sum_yy);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (has_room) begin
                        n_state = S_MUL_XX;
                    end else if (i_last_point) begin
                        n_state = S_MOM;
                    end
                end
            end
            S_MUL_XX: n_state = S_MUL_YY;
            S_MUL_YY: n_state = S_MUL_XY;
            S_MUL_XY: n_state = r_last ? S_MOM : S_IDLE;
            S_MOM: begin
                if (r_step == MOM_SX_SY) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_ABS;
            S_ABS:    n_state = acc_zero ? S_FINISH : S_NORM;
            S_NORM: begin
                if (norm_done) begin
                    n_state = S_CORDIC;
                end
            end
            S_CORDIC: begin
                if (r_iter == ITER_W'(ITERS - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mac_shift = 1'b0;
        mac_op    = MAC_NONE;
        case (r_state)
            S_MUL_XX: begin
                mul_a  = MUL_W'(r_x);
                mul_b  = MUL_W'(r_x);
                mac_op = MAC_SXX;
            end
            S_MUL_YY: begin
                mul_a  = MUL_W'(r_y);
                mul_b  = MUL_W'(r_y);
                mac_op = MAC_SYY;
            end
            S_MUL_XY: begin
                mul_a  = MUL_W'(r_x);
                mul_b  = MUL_W'(r_y);
                mac_op = MAC_SXY;
            end
            S_MOM: begin
                case (r_step)
                    MOM_XX_LO: begin
                        mul_a  = MUL_W'(r_count);
                        mul_b  = MUL_W'(dxx[LO_W-1:0]);
                        mac_op = MAC_X_LOAD;
                    end
                    MOM_XX_HI: begin
                        mul_a     = MUL_W'(r_count);
                        mul_b     = MUL_W'(signed'(dxx[XY_W-1:LO_W]));
                        mac_shift = 1'b1;
                        mac_op    = MAC_X_ADD;
                    end
                    MOM_SX_SQ: begin
                        mul_a  = MUL_W'(r_sum_x);
                        mul_b  = MUL_W'(r_sum_x);
                        mac_op = MAC_X_SUB;
                    end
                    MOM_SY_SQ: begin
                        mul_a  = MUL_W'(r_sum_y);
                        mul_b  = MUL_W'(r_sum_y);
                        mac_op = MAC_X_ADD;
                    end
                    MOM_XY_LO: begin
                        mul_a  = MUL_W'(r_count);
                        mul_b  = MUL_W'(r_sum_xy[LO_W-1:0]);
                        mac_op = MAC_Y_LOAD;
                    end
                    MOM_XY_HI: begin
                        mul_a     = MUL_W'(r_count);
                        mul_b     = MUL_W'(signed'(r_sum_xy[XY_W-1:LO_W]));
                        mac_shift = 1'b1;
                        mac_op    = MAC_Y_ADD;
                    end
                    MOM_SX_SY: begin
                        mul_a  = MUL_W'(r_sum_x);
                        mul_b  = MUL_W'(r_sum_y);
                        mac_op = MAC_Y_SUB;
                    end
                    default: begin
                        mac_op = MAC_NONE;
                    end
                endcase
            end
            default: begin
                mac_op = MAC_NONE;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign prod_sh = mac_shift ? (ACC_W'(prod) <<< LO_W) : ACC_W'(prod);

    assign x_ext   = MAG_W'(r_acc_x);
    assign y_ext2  = MAG_W'(r_acc_y) <<< 1;
    assign ax_abs  = x_ext[MAG_W-1] ? unsigned'(-x_ext) : unsigned'(x_ext);
    assign ay_abs  = y_ext2[MAG_W-1] ? unsigned'(-y_ext2) : unsigned'(y_ext2);
    assign mag_max = (r_ax > r_ay) ? r_ax : r_ay;

    always_comb begin
        n_ax      = r_ax;
        n_ay      = r_ay;
        norm_done = 1'b0;
        if (mag_max >= M_RIGHT4) begin
            n_ax = r_ax >> 4;
            n_ay = r_ay >> 4;
        end else if (mag_max >= M_RIGHT1) begin
            n_ax = r_ax >> 1;
            n_ay = r_ay >> 1;
        end else if (mag_max < M_LEFT4) begin
            n_ax = r_ax << 4;
            n_ay = r_ay << 4;
        end else if (mag_max < M_LEFT1) begin
            n_ax = r_ax << 1;
            n_ay = r_ay << 1;
        end else begin
            norm_done = 1'b1;
        end
    end

    assign sx  = shr_tz(r_cx, r_iter);
    assign sy  = shr_tz(r_cy, r_iter);
    assign ang = ANG_W'(cordic_angle(r_iter));

    always_comb begin
        if (!r_cy[CRD_W-1]) begin
            n_cx = r_cx + sy;
            n_cy = r_cy - sx;
            n_z  = r_z + ang;
        end else begin
            n_cx = r_cx - sy;
            n_cy = r_cy + sx;
            n_z  = r_z - ang;
        end
    end

    always_comb begin
        if (r_z[ANG_W-1]) begin
            z_clamp = '0;
        end else if (r_z > Z_MAX) begin
            z_clamp = Z_MAX;
        end else begin
            z_clamp = r_z;
        end
        case ({r_neg_x, r_neg_y})
            2'b00:   w = W_HALF - W_W'(z_clamp);
            2'b01:   w = W_HALF + W_W'(z_clamp);
            2'b10:   w = W_W'(z_clamp);
            2'b11:   w = W_FULL - W_W'(z_clamp);
            default: w = W_HALF - W_W'(z_clamp);
        endcase
        w_round = w + W_ROUND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mac_op    <= MAC_NONE;
            r_step      <= MOM_XX_LO;
            r_count     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_xx    <= '0;
            r_sum_yy    <= '0;
            r_sum_xy    <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mac_op <= mac_op;

            if (in_fire) begin
                if (has_room) begin
                    r_count <= r_count + CNT_W'(1);
                    r_sum_x <= r_sum_x + SUM_W'(i_x_coord);
                    r_sum_y <= r_sum_y + SUM_W'(i_y_coord);
                end else begin
                    r_dropped <= 1'b1;
                end
            end

            if (r_state == S_MOM) begin
                r_step <= (r_step == MOM_SX_SY) ? MOM_XX_LO : t_mom_step'(r_step + 3'd1);
            end

            case (r_mac_op)
                MAC_SXX:    r_sum_xx <= r_sum_xx + SQ_W'(r_prod);
                MAC_SYY:    r_sum_yy <= r_sum_yy + SQ_W'(r_prod);
                MAC_SXY:    r_sum_xy <= r_sum_xy + XY_W'(r_prod);
                default:    ;
            endcase

            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_sum_x     <= '0;
                r_sum_y     <= '0;
                r_sum_xx    <= '0;
                r_sum_yy    <= '0;
                r_sum_xy    <= '0;
                r_dropped   <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_sh;

        if (in_fire) begin
            r_x    <= i_x_coord;
            r_y    <= i_y_coord;
            r_last <= i_last_point;
        end

        case (r_mac_op)
            MAC_X_LOAD: r_acc_x <= r_prod;
            MAC_X_ADD:  r_acc_x <= r_acc_x + r_prod;
            MAC_X_SUB:  r_acc_x <= r_acc_x - r_prod;
            MAC_Y_LOAD: r_acc_y <= r_prod;
            MAC_Y_ADD:  r_acc_y <= r_acc_y + r_prod;
            MAC_Y_SUB:  r_acc_y <= r_acc_y - r_prod;
            default:    ;
        endcase

        if (r_state == S_ABS) begin
            r_ax    <= ax_abs;
            r_ay    <= ay_abs;
            r_neg_x <= r_acc_x[ACC_W-1];
            r_neg_y <= r_acc_y[ACC_W-1];
            r_zero  <= acc_zero;
        end

        if (r_state == S_NORM) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
            if (norm_done) begin
                r_cx   <= CRD_W'(r_ax);
                r_cy   <= CRD_W'(r_ay);
                r_z    <= '0;
                r_iter <= '0;
            end
        end

        if (r_state == S_CORDIC) begin
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_z    <= n_z;
            r_iter <= r_iter + ITER_W'(1);
        end

        if (r_state == S_FINISH && out_free) begin
            r_azimuth     <= r_zero ? AZ_NO_MOMENT : w_round[31:16];
            r_point_count <= r_count;
            r_overflow    <= r_dropped;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_azimuth     = r_azimuth;
    assign o_point_count = r_point_count;
    assign o_overflow    = r_overflow;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("Point count exceeds capacity.");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORDIC && r_iter == '0) |->
        ((r_cx >= C_LO || r_cy >= C_LO) && r_cx < C_HI && r_cy < C_HI
         && !r_cx[CRD_W-1] && !r_cy[CRD_W-1]))
        else $error("CORDIC started on operands outside the normalized range.");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORDIC) |-> (r_iter < ITER_W'(ITERS)))
        else $error("CORDIC iteration counter out of range.");

    a_mac_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ABS || r_state == S_NORM || r_state == S_CORDIC) |->
        (r_mac_op == MAC_NONE))
        else $error("Multiplier result still pending after the moment phase.");

    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && out_free) |=>
        (r_out_valid && r_count == '0 && !r_dropped && r_state == S_IDLE))
        else $error("Line state not cleared when the result was loaded.");
`endif

endmodule

// File: bench/lofm_orientation_checker.sv
// Checker for the line orientation core: watches both channels, predicts each line result and compares.
module lofm_orientation_checker import lofm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic                      i_last_point,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [AZ_W-1:0]           i_azimuth,
    input  logic [CNT_W-1:0]          i_point_count,
    input  logic                      i_overflow,
    output int                        o_pending,
    output int                        o_mismatches
);

    localparam longint ONE29 = 64'sd536870912;
    localparam longint ONE30 = 64'sd1073741824;
    localparam longint ONE31 = 64'sd2147483648;

    typedef struct packed {
        logic [AZ_W-1:0]  azimuth;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } t_line_result;

    longint atan_step [30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    int                       line_count   = 0;
    logic signed [SUM_W-1:0]  acc_x        = '0;
    logic signed [SUM_W-1:0]  acc_y        = '0;
    logic signed [SQ_W-1:0]   acc_xx       = '0;
    logic signed [SQ_W-1:0]   acc_yy       = '0;
    logic signed [XY_W-1:0]   acc_xy       = '0;
    logic                     line_dropped = 1'b0;
    t_line_result             expected_lines [$];
    t_line_result             want;
    int                       mismatch_total = 0;

    function automatic longint trunc_shift(input longint v, input int s);
        return (v >= 0) ? (v >>> s) : -((-v) >>> s);
    endfunction

    function automatic logic [AZ_W-1:0] orientation_of(input longint dx, input longint dy);
        longint     ax, ay, big, cx, cy, nx, ny, z, ang;
        logic [63:0] wv;
        if (dx == 0 && dy == 0) begin
            return 16'h8000;
        end
        ax  = (dx < 0) ? -dx : dx;
        ay  = (dy < 0) ? -dy : dy;
        big = (ax > ay) ? ax : ay;
        while (big >= ONE30) begin
            ax  = ax >>> 1;
            ay  = ay >>> 1;
            big = big >>> 1;
        end
        while (big < ONE29) begin
            ax  = ax <<< 1;
            ay  = ay <<< 1;
            big = big <<< 1;
        end
        cx = ax;
        cy = ay;
        z  = 0;
        for (int i = 0; i < 30; i++) begin
            if (cy >= 0) begin
                nx = cx + trunc_shift(cy, i);
                ny = cy - trunc_shift(cx, i);
                z  = z + atan_step[i];
            end else begin
                nx = cx - trunc_shift(cy, i);
                ny = cy + trunc_shift(cx, i);
                z  = z - atan_step[i];
            end
            cx = nx;
            cy = ny;
        end
        if (z < 0) z = 0;
        if (z > ONE30) z = ONE30;
        if (dx >= 0) begin
            ang = (dy >= 0) ? z : -z;
        end else begin
            ang = (dy >= 0) ? ONE31 - z : z - ONE31;
        end
        wv = ONE31 - ang;
        wv = (wv + 64'd32768) >> 16;
        return wv[AZ_W-1:0];
    endfunction

    task automatic absorb_point(
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py,
        input logic                      plast
    );
        longint       n, sxx, syy, sxy;
        t_line_result res;
        if (line_count < MAX_POINTS) begin
            line_count = line_count + 1;
            acc_x      = acc_x + px;
            acc_y      = acc_y + py;
            acc_xx     = acc_xx + px * px;
            acc_yy     = acc_yy + py * py;
            acc_xy     = acc_xy + px * py;
        end else begin
            line_dropped = 1'b1;
        end
        if (plast) begin
            n   = longint'(line_count);
            sxx = n * longint'(acc_xx) - longint'(acc_x) * longint'(acc_x);
            syy = n * longint'(acc_yy) - longint'(acc_y) * longint'(acc_y);
            sxy = n * longint'(acc_xy) - longint'(acc_x) * longint'(acc_y);
            res.azimuth  = orientation_of(sxx - syy, 2 * sxy);
            res.count    = line_count[CNT_W-1:0];
            res.overflow = line_dropped;
            expected_lines = {expected_lines, res};
            line_count   = 0;
            acc_x        = '0;
            acc_y        = '0;
            acc_xx       = '0;
            acc_yy       = '0;
            acc_xy       = '0;
            line_dropped = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("mismatch on %s: got %0d, expected %0d", what, got, exp_val);
        mismatch_total = mismatch_total + 1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                absorb_point(i_x_coord, i_y_coord, i_last_point);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_lines.size() == 0) begin
                    report_mismatch("unexpected result azimuth", i_azimuth, -1);
                end else begin
                    want = expected_lines.pop_front();
                    if (i_azimuth !== want.azimuth)
                        report_mismatch("azimuth", i_azimuth, want.azimuth);
                    if (i_point_count !== want.count)
                        report_mismatch("point_count", i_point_count, want.count);
                    if (i_overflow !== want.overflow)
                        report_mismatch("overflow", i_overflow, want.overflow);
                end
            end
        end
        o_pending    <= expected_lines.size();
        o_mismatches <= mismatch_total;
    end

endmodule

// File: bench/tb_line_orientation_from_moments_core.sv
// Testbench top for the line orientation core: clock, reset, point stimulus, result handshake, verdict.
module tb_line_orientation_from_moments_core;
    import lofm_pkg::*;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] x_coord   = '0;
    logic signed [COORD_W-1:0] y_coord   = '0;
    logic                      last_point = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [AZ_W-1:0]           azimuth;
    logic [CNT_W-1:0]          point_count;
    logic                      overflow;
    int                        pending;
    int                        mismatches;

    bit snd_burst   = 1'b0;
    bit rcv_burst   = 1'b0;
    int points_sent = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    line_orientation_from_moments_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_x_coord     (x_coord),
        .i_y_coord     (y_coord),
        .i_last_point  (last_point),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_azimuth     (azimuth),
        .o_point_count (point_count),
        .o_overflow    (overflow)
    );

    lofm_orientation_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_x_coord     (x_coord),
        .i_y_coord     (y_coord),
        .i_last_point  (last_point),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_azimuth     (azimuth),
        .i_point_count (point_count),
        .i_overflow    (overflow),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    task automatic send_point(
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py,
        input logic                      plast
    );
        int gap;
        gap = snd_burst ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 24) == 0) snd_burst = !snd_burst;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        x_coord    <= px;
        y_coord    <= py;
        last_point <= plast;
        do @(posedge clk); while (!(in_valid && in_ready));
        points_sent = points_sent + 1;
    endtask

    // Shapes: full-range noise, a noisy straight segment, one repeated point, an axis-aligned segment.
    task automatic send_line(input int n_pts, input int shape);
        int          x0, y0, dx, dy, px, py;
        logic [31:0] r;
        x0 = int'($urandom_range(0, 32000)) - 16000;
        y0 = int'($urandom_range(0, 32000)) - 16000;
        dx = int'($urandom_range(0, 600)) - 300;
        dy = int'($urandom_range(0, 600)) - 300;
        if (shape == 3) begin
            if ($urandom_range(0, 1) == 0) dx = 0; else dy = 0;
        end
        for (int k = 0; k < n_pts; k++) begin
            case (shape)
                0: begin
                    r  = $urandom;
                    px = int'(signed'(r[15:0]));
                    py = int'(signed'(r[31:16]));
                end
                1: begin
                    px = x0 + k * dx + int'($urandom_range(0, 6)) - 3;
                    py = y0 + k * dy + int'($urandom_range(0, 6)) - 3;
                end
                2: begin
                    px = x0;
                    py = y0;
                end
                default: begin
                    px = x0 + k * dx;
                    py = y0 + k * dy;
                end
            endcase
            send_point(px[COORD_W-1:0], py[COORD_W-1:0], k == n_pts - 1);
        end
    endtask

    initial begin
        int random_base;
        int n_pts;
        int pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_point(16'sd0, 16'sd0, 1'b1);
        send_point(-16'sd32768, 16'sd32767, 1'b1);
        send_point(16'sd5, 16'sd5, 1'b0);
        send_point(16'sd5, 16'sd5, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd100, 16'sd0, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd100, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd100, 16'sd100, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd100, -16'sd100, 1'b1);
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b1);
        send_point(16'sd32767, -16'sd32768, 1'b0);
        send_point(-16'sd32768, 16'sd32767, 1'b1);
        send_point(16'sd10, -16'sd3, 1'b0);
        send_point(-16'sd7, 16'sd20, 1'b0);
        send_point(16'sd1, 16'sd1, 1'b0);
        send_point(-16'sd1, -16'sd1, 1'b1);

        random_base = points_sent;
        while (points_sent - random_base < 480) begin
            n_pts = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
            pick  = $urandom_range(0, 9);
            if (pick < 3)      send_line(n_pts, 0);
            else if (pick < 8) send_line(n_pts, 1);
            else if (pick < 9) send_line(n_pts, 2);
            else               send_line(n_pts, 3);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Once the fifteenth result is in, the receiver holds off long enough for the core to back up.
    initial begin
        int hold;
        int results_taken;
        results_taken = 0;
        wait (rst_n);
        forever begin
            if (results_taken == 15) hold = 400;
            else if (rcv_burst)      hold = 0;
            else                     hold = $urandom_range(0, 13);
            if ($urandom_range(0, 24) == 0) rcv_burst = !rcv_burst;
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            results_taken = results_taken + 1;
        end
    end

    initial begin
        #12_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
